// ===== rtl/rfpr_pkg.sv =====
// rfpr_pkg: shared types, character codes and operation kinds for the
// rangefinder frame parser; no dependencies
`timescale 1ns / 1ps

package rfpr_pkg;

    // default for the top level line length, and the depth of both queues
    localparam int LINE_MAX_DEF = 10;
    localparam int QUEUE_DEPTH  = 2;

    // input command codes
    localparam logic CMD_BYTE   = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    // ascii codes
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_R    = 8'h52;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_VT   = 8'h0B;
    localparam logic [7:0] CH_FF   = 8'h0C;

    // distance values
    localparam int          DIST_W        = 14;
    localparam logic [13:0] NO_TARGET     = 14'd9999;
    localparam logic [13:0] MAX_DIST_RST  = 14'd9998;
    localparam logic [14:0] DIST_NONE     = 15'h7FFF;

    // report status codes
    localparam logic [1:0] ST_VALID     = 2'd0;
    localparam logic [1:0] ST_NO_TARGET = 2'd1;
    localparam logic [1:0] ST_NO_FRAME  = 2'd2;

    // operation kinds handed from front to back
    localparam logic [2:0] KIND_REPORT = 3'd0;
    localparam logic [2:0] KIND_CR     = 3'd1;
    localparam logic [2:0] KIND_SPACE  = 3'd2;
    localparam logic [2:0] KIND_R      = 3'd3;
    localparam logic [2:0] KIND_DIGIT  = 3'd4;
    localparam logic [2:0] KIND_OTHER  = 3'd5;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] digit;
    } op_t;

    typedef struct packed {
        logic [31:0]        seq;
        logic signed [14:0] distance;
        logic [1:0]         status;
    } result_t;

endpackage

// ===== rtl/rfpr_queue.sv =====
// rfpr_queue: small first-in first-out word queue with push/full and pop/empty
// depends on nothing; depth must be a power of two, at least 2
`timescale 1ns / 1ps

module rfpr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (AW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/rfpr_front.sv =====
// rfpr_front: input side; accepts words, drops line feeds and classifies the rest
// depends on rfpr_pkg
`timescale 1ns / 1ps

module rfpr_front
    import rfpr_pkg::*;
(
    input  logic       push,
    input  logic       command,
    input  logic [7:0] rx_byte,
    output logic       full,
    input  logic       q_full,
    output logic       q_push,
    output op_t        q_op
);

    logic is_lf;

    assign is_lf  = (command == CMD_BYTE) && (rx_byte == CH_LF);
    assign full   = q_full;
    assign q_push = push && !q_full && !is_lf;

    always_comb
    begin
        q_op.digit = rx_byte[3:0];
        if (command == CMD_REPORT)
        begin
            q_op.kind = KIND_REPORT;
        end
        else if (rx_byte == CH_CR)
        begin
            q_op.kind = KIND_CR;
        end
        else if (rx_byte == CH_SP || rx_byte == CH_TAB ||
                 rx_byte == CH_VT || rx_byte == CH_FF)
        begin
            q_op.kind = KIND_SPACE;
        end
        else if (rx_byte == CH_R)
        begin
            q_op.kind = KIND_R;
        end
        else if (rx_byte >= CH_ZERO && rx_byte <= CH_NINE)
        begin
            q_op.kind = KIND_DIGIT;
        end
        else
        begin
            q_op.kind = KIND_OTHER;
        end
    end

endmodule

// ===== rtl/rfpr_back.sv =====
// rfpr_back: execution side; runs the line parser and builds report words
// depends on rfpr_pkg
`timescale 1ns / 1ps

module rfpr_back
    import rfpr_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  op_t         op,
    input  logic        op_empty,
    output logic        op_pop,
    input  logic [13:0] max_dist,
    input  logic        res_full,
    output logic        res_push,
    output result_t     res
);

    localparam int                LEN_W    = $clog2(LINE_MAX + 1);
    localparam logic [LEN_W-1:0]  LEN_FULL = LEN_W'(LINE_MAX);

    // parser states
    localparam logic [1:0] P_LEAD  = 2'd0;
    localparam logic [1:0] P_NUM   = 2'd1;
    localparam logic [1:0] P_TRAIL = 2'd2;
    localparam logic [1:0] P_BAD   = 2'd3;

    logic [LEN_W-1:0] len_reg, len_next;
    logic [1:0]       pstate_reg, pstate_next;
    logic [2:0]       ndig_reg, ndig_next;
    logic [13:0]      value_reg, value_next;
    logic [13:0]      last_reg, last_next;
    logic             seen_reg, seen_next;
    logic [31:0]      count_reg, count_next;
    logic             is_report;
    logic [13:0]      value_x10;

    assign is_report = (op.kind == KIND_REPORT);
    assign op_pop    = !op_empty && (!is_report || !res_full);
    assign res_push  = op_pop && is_report;
    assign value_x10 = {value_reg[10:0], 3'b000} + {value_reg[12:0], 1'b0} + {10'd0, op.digit};

    // report word from the state before this request
    always_comb
    begin
        res.seq = count_reg + 32'd1;
        if (!seen_reg)
        begin
            res.distance = DIST_NONE;
            res.status   = ST_NO_FRAME;
        end
        else if (last_reg == NO_TARGET)
        begin
            res.distance = {1'b0, NO_TARGET};
            res.status   = ST_NO_TARGET;
        end
        else if (last_reg <= max_dist)
        begin
            res.distance = {1'b0, last_reg};
            res.status   = ST_VALID;
        end
        else
        begin
            res.distance = DIST_NONE;
            res.status   = ST_NO_FRAME;
        end
    end

    always_comb
    begin
        len_next    = len_reg;
        pstate_next = pstate_reg;
        ndig_next   = ndig_reg;
        value_next  = value_reg;
        last_next   = last_reg;
        seen_next   = seen_reg;
        count_next  = count_reg;
        if (op_pop)
        begin
            case (op.kind)
                KIND_REPORT:
                begin
                    count_next = count_reg + 32'd1;
                    seen_next  = 1'b0;
                end
                KIND_CR:
                begin
                    if (len_reg != '0 &&
                        ((pstate_reg == P_NUM && ndig_reg == 3'd4) ||
                         pstate_reg == P_TRAIL))
                    begin
                        last_next = value_reg;
                        seen_next = 1'b1;
                    end
                    len_next    = '0;
                    pstate_next = P_LEAD;
                    ndig_next   = '0;
                    value_next  = '0;
                end
                default:
                begin
                    if (len_reg == LEN_FULL)
                    begin
                        // line overflow: drop the line and this byte
                        len_next    = '0;
                        pstate_next = P_LEAD;
                        ndig_next   = '0;
                        value_next  = '0;
                    end
                    else
                    begin
                        len_next = len_reg + LEN_W'(1);
                        case (pstate_reg)
                            P_LEAD:
                            begin
                                if (op.kind == KIND_R)
                                begin
                                    pstate_next = P_NUM;
                                    ndig_next   = '0;
                                    value_next  = '0;
                                end
                                else if (op.kind != KIND_SPACE)
                                begin
                                    pstate_next = P_BAD;
                                end
                            end
                            P_NUM:
                            begin
                                if (op.kind == KIND_DIGIT && ndig_reg != 3'd4)
                                begin
                                    ndig_next  = ndig_reg + 3'd1;
                                    value_next = value_x10;
                                end
                                else if (op.kind == KIND_SPACE && ndig_reg == 3'd4)
                                begin
                                    pstate_next = P_TRAIL;
                                end
                                else
                                begin
                                    pstate_next = P_BAD;
                                end
                            end
                            P_TRAIL:
                            begin
                                if (op.kind != KIND_SPACE)
                                begin
                                    pstate_next = P_BAD;
                                end
                            end
                            default:
                            begin
                                pstate_next = P_BAD;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            pstate_reg <= P_LEAD;
            ndig_reg   <= '0;
            seen_reg   <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            len_reg    <= len_next;
            pstate_reg <= pstate_next;
            ndig_reg   <= ndig_next;
            seen_reg   <= seen_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        last_reg  <= last_next;
    end

endmodule

// ===== rtl/range_frame_parse_and_report_unit.sv =====
// range_frame_parse_and_report_unit: top level of the rangefinder frame parser
// depends on rfpr_pkg, rfpr_front, rfpr_queue, rfpr_back
`timescale 1ns / 1ps

// takes one word per clock while full is low: a sensor byte (command 0) or a
// report request (command 1). bytes are parsed as they arrive, so the line
// never has to be rescanned; a carriage return closes the line. a report word
// enters the result queue when the parser pops its request, and shows on the
// result ports once it is at the queue head. the input stalls (full) only once the
// two-word operation queue has filled behind a report request that could not
// enter a full result queue; line feeds are dropped at the input and never
// reach the parser. max_valid_distance is written through cfg_wr_en /
// cfg_wr_data and resets to 9998; write it only while no words are in flight.

module range_frame_parse_and_report_unit
    import rfpr_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // input word queue side
    input  logic               push,
    output logic               full,
    input  logic               command,
    input  logic [7:0]         rx_byte,
    // result word queue side
    output logic               empty,
    input  logic               pop,
    output logic [31:0]        sequence_res,
    output logic signed [14:0] distance,
    output logic [1:0]         status,
    // configuration
    input  logic               cfg_wr_en,
    input  logic [13:0]        cfg_wr_data
);

    logic [13:0] max_dist_reg;

    // front to operation queue
    logic    opq_push, opq_full, opq_pop, opq_empty;
    op_t     opq_wdata, opq_rdata;

    // back to result queue
    logic    resq_push, resq_full;
    result_t resq_wdata, resq_rdata;

    // max valid distance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dist_reg <= MAX_DIST_RST;
        end
        else if (cfg_wr_en)
        begin
            max_dist_reg <= cfg_wr_data;
        end
    end

    // classify input words
    rfpr_front u_front (
        .push    (push),
        .command (command),
        .rx_byte (rx_byte),
        .full    (full),
        .q_full  (opq_full),
        .q_push  (opq_push),
        .q_op    (opq_wdata)
    );

    // decouples the input from the parser
    rfpr_queue #(
        .WIDTH ($bits(op_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_op_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (opq_push),
        .wdata (opq_wdata),
        .full  (opq_full),
        .pop   (opq_pop),
        .rdata (opq_rdata),
        .empty (opq_empty)
    );

    // line parser and report builder
    rfpr_back #(
        .LINE_MAX (LINE_MAX)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (opq_rdata),
        .op_empty (opq_empty),
        .op_pop   (opq_pop),
        .max_dist (max_dist_reg),
        .res_full (resq_full),
        .res_push (resq_push),
        .res      (resq_wdata)
    );

    // result words wait here until popped
    rfpr_queue #(
        .WIDTH ($bits(result_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (resq_push),
        .wdata (resq_wdata),
        .full  (resq_full),
        .pop   (pop),
        .rdata (resq_rdata),
        .empty (empty)
    );

    assign sequence_res = resq_rdata.seq;
    assign distance     = resq_rdata.distance;
    assign status       = resq_rdata.status;

endmodule
